// ----- rtl/bbs_pkg.sv -----
// Shared types and constants for the mesh bounding box and sphere unit.
// No dependencies; imported by bbs_ctrl, bbs_dp, the top level and the testbench.
`default_nettype none
package bbs_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_COORD_WIDTH  = 32;

    localparam int HALF_W   = 31;
    localparam int RADIUS_W = 33;
    localparam int TOTAL_W  = 13;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W   = $clog2(SQRT_STEPS);

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [63:0]        SQRT_BIT_INIT = 64'h4000_0000_0000_0000;

    // controller -> datapath
    typedef struct packed {
        logic load;       // vertex request taken this cycle
        logic calc;       // form half extents and center
        logic issue;      // read next stored vertex
        logic sqrt_init;  // load root unit with largest squared distance
        logic sqrt_step;  // one root digit
        logic emit;       // latch result, clear mesh state
    } bbs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;   // current read is the last stored vertex
        logic pipe_empty; // distance pipeline drained
        logic sqrt_last;  // final root digit this cycle
    } bbs_stat_t;

endpackage
`default_nettype wire

// ----- rtl/bbs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bbs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/bbs_ctrl.sv -----
// Sequencer for the bounding box and sphere unit.
// Depends on bbs_pkg.
`default_nettype none
module bbs_ctrl
    import bbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      is_last,
    input  wire bbs_stat_t stat,
    output bbs_cmd_t       cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_SCAN,
        S_DRAIN,
        S_SQRT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start && is_last)
                begin
                    state_next = S_CENTER;
                end
            end
            S_CENTER:
            begin
                cmd.calc   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- rtl/bbs_dp.sv -----
// Datapath: vertex stores, min/max tracking, distance pipeline, root unit.
// Depends on bbs_pkg and bbs_ram.
`default_nettype none
module bbs_dp
    import bbs_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bbs_cmd_t            cmd,
    output bbs_stat_t                stat,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  pos_z,
    output logic signed [31:0]       center_x,
    output logic signed [31:0]       center_y,
    output logic signed [31:0]       center_z,
    output logic [HALF_W-1:0]        half_x,
    output logic [HALF_W-1:0]        half_y,
    output logic [HALF_W-1:0]        half_z,
    output logic [RADIUS_W-1:0]      radius,
    output logic [TOTAL_W-1:0]       vertex_total,
    output logic                     overflowed
);

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [COORD_WIDTH-1:0] pos_raw [3];
    logic signed [31:0]     pos_s   [3];
    logic [COORD_WIDTH-1:0] rd_data [3];

    logic signed [31:0] min_reg [3];
    logic signed [31:0] max_reg [3];
    logic [CNT_W-1:0]   count_reg;
    logic               ovf_reg;
    logic               room;

    logic signed [31:0] ctr_reg  [3];
    logic [HALF_W-1:0]  half_reg [3];
    logic signed [32:0] span     [3];
    logic [HALF_W-1:0]  half_c   [3];

    logic [AW-1:0]      rd_addr_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [32:0] diff     [3];
    logic [31:0]        mag_reg  [3];
    logic [63:0]        sq_reg   [3];
    logic [63:0]        sum_reg;
    logic [63:0]        best_reg;

    logic [63:0]        n_reg, root_reg, bit_reg, trial;
    logic [STEP_W-1:0]  step_reg;

    logic signed [31:0] ctr_out_reg  [3];
    logic [HALF_W-1:0]  half_out_reg [3];
    logic [RADIUS_W-1:0] radius_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                ovf_out_reg;

    assign pos_raw[0] = pos_x[COORD_WIDTH-1:0];
    assign pos_raw[1] = pos_y[COORD_WIDTH-1:0];
    assign pos_raw[2] = pos_z[COORD_WIDTH-1:0];
    assign room = (count_reg < CNT_W'(MAX_VERTICES));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pos_s[a]  = 32'(signed'(pos_raw[a]));
            span[a]   = 33'(max_reg[a]) - 33'(min_reg[a]);
            half_c[a] = span[a][HALF_W:1];
            diff[a]   = 33'(signed'(rd_data[a])) - 33'(ctr_reg[a]);
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_store
        bbs_ram #(
            .WIDTH (COORD_WIDTH),
            .DEPTH (MAX_VERTICES),
            .ADDR_W(AW)
        ) u_ram (
            .clk  (clk),
            .we   (cmd.load && room),
            .waddr(count_reg[AW-1:0]),
            .wdata(pos_raw[g]),
            .raddr(rd_addr_reg),
            .rdata(rd_data[g])
        );
    end

    // mesh accumulation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= COORD_MAX;
                max_reg[a] <= COORD_MIN;
            end
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.emit)
        begin
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= COORD_MAX;
                max_reg[a] <= COORD_MIN;
            end
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (room)
            begin
                count_reg <= count_reg + 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    if (pos_s[a] < min_reg[a]) min_reg[a] <= pos_s[a];
                    if (pos_s[a] > max_reg[a]) max_reg[a] <= pos_s[a];
                end
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // pipeline valids, read address and root step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.calc)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.sqrt_init)
            begin
                step_reg <= '0;
            end
            else if (cmd.sqrt_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign trial = root_reg + bit_reg;

    // payload path
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            for (int a = 0; a < 3; a++)
            begin
                half_reg[a] <= half_c[a];
                ctr_reg[a]  <= min_reg[a] + 32'(half_c[a]);
            end
            best_reg <= '0;
        end
        else if (v4_reg && (sum_reg > best_reg))
        begin
            best_reg <= sum_reg;
        end

        for (int a = 0; a < 3; a++)
        begin
            mag_reg[a] <= diff[a][32] ? 32'(-diff[a]) : diff[a][31:0];
            sq_reg[a]  <= 64'(mag_reg[a]) * 64'(mag_reg[a]);
        end
        sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];

        // digit-by-digit square root, two bits of radicand per step
        if (cmd.sqrt_init)
        begin
            n_reg    <= best_reg;
            root_reg <= '0;
            bit_reg  <= SQRT_BIT_INIT;
        end
        else if (cmd.sqrt_step)
        begin
            if (n_reg >= trial)
            begin
                n_reg    <= n_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.emit)
        begin
            for (int a = 0; a < 3; a++)
            begin
                ctr_out_reg[a]  <= ctr_reg[a];
                half_out_reg[a] <= half_reg[a];
            end
            radius_reg  <= RADIUS_W'(root_reg);
            total_reg   <= TOTAL_W'(count_reg);
            ovf_out_reg <= ovf_reg;
        end
    end

    assign stat.scan_end   = (CNT_W'(rd_addr_reg) == (count_reg - 1'b1));
    assign stat.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign stat.sqrt_last  = (step_reg == STEP_W'(SQRT_STEPS - 1));

    assign center_x     = ctr_out_reg[0];
    assign center_y     = ctr_out_reg[1];
    assign center_z     = ctr_out_reg[2];
    assign half_x       = half_out_reg[0];
    assign half_y       = half_out_reg[1];
    assign half_z       = half_out_reg[2];
    assign radius       = radius_reg;
    assign vertex_total = total_reg;
    assign overflowed   = ovf_out_reg;

endmodule
`default_nettype wire

// ----- rtl/mesh_bounding_box_and_sphere_unit.sv -----
// Mesh bounding box and bounding sphere unit (top level).
// Depends on bbs_pkg, bbs_ctrl, bbs_dp, bbs_ram.
// Throughput: one vertex request per cycle while busy is low. A request
// with is_last holds busy through center calc, one RAM read per vertex,
// a 4-stage distance pipeline drain and a 32-step root unit. The result
// strobe (done) is asserted in the same cycle that busy falls. Receiver
// cannot stall. Async reset clears mesh state; vertex stores need no
// clearing.
`default_nettype none
module mesh_bounding_box_and_sphere_unit
    import bbs_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic               is_last,
    output logic                    done,
    output logic signed [31:0]      center_x,
    output logic signed [31:0]      center_y,
    output logic signed [31:0]      center_z,
    output logic [HALF_W-1:0]       half_x,
    output logic [HALF_W-1:0]       half_y,
    output logic [HALF_W-1:0]       half_z,
    output logic [RADIUS_W-1:0]     radius,
    output logic [TOTAL_W-1:0]      vertex_total,
    output logic                    overflowed
);

    bbs_cmd_t  cmd;
    bbs_stat_t stat;

    // Sequencer: accepts requests in idle, then walks center, scan, drain,
    // root and emit.
    bbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .is_last(is_last),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath: stores, min/max, squared distance max search, integer sqrt.
    bbs_dp #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .half_x      (half_x),
        .half_y      (half_y),
        .half_z      (half_z),
        .radius      (radius),
        .vertex_total(vertex_total),
        .overflowed  (overflowed)
    );

endmodule
`default_nettype wire

// ----- sim/mesh_bounding_box_and_sphere_unit_tb.sv -----
// Testbench for mesh_bounding_box_and_sphere_unit: drives vertex requests, predicts
// the box center, half extents and bounding radius per mesh, and checks each result.
// Depends on bbs_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module mesh_bounding_box_and_sphere_unit_tb;
    import bbs_pkg::*;

    localparam int CAP = DEF_MAX_VERTICES;

    // one pending vertex request
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } vertex_t;

    // one predicted mesh summary
    typedef struct {
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic signed [31:0]  cz;
        logic [HALF_W-1:0]   hx;
        logic [HALF_W-1:0]   hy;
        logic [HALF_W-1:0]   hz;
        logic [RADIUS_W-1:0] rad;
        logic [TOTAL_W-1:0]  total;
        logic                ovf;
    } summary_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic is_last;
    logic done;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [HALF_W-1:0] half_x;
    logic [HALF_W-1:0] half_y;
    logic [HALF_W-1:0] half_z;
    logic [RADIUS_W-1:0] radius;
    logic [TOTAL_W-1:0] vertex_total;
    logic overflowed;

    mesh_bounding_box_and_sphere_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .is_last     (is_last),
        .done        (done),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .half_x      (half_x),
        .half_y      (half_y),
        .half_z      (half_z),
        .radius      (radius),
        .vertex_total(vertex_total),
        .overflowed  (overflowed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    vertex_t  pending_q[$];     // vertex requests not yet accepted
    summary_t summary_q[$];     // predicted summaries awaiting done
    int       mismatch_count = 0;
    bit       stim_done = 0;

    // mirror of the unit's mesh state
    logic signed [31:0] mesh_x[CAP];
    logic signed [31:0] mesh_y[CAP];
    logic signed [31:0] mesh_z[CAP];
    logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    int  mesh_count;
    bit  mesh_dropped;

    task automatic clear_mesh_state();
        lo_x = COORD_MAX; lo_y = COORD_MAX; lo_z = COORD_MAX;
        hi_x = COORD_MIN; hi_y = COORD_MIN; hi_z = COORD_MIN;
        mesh_count = 0;
        mesh_dropped = 0;
    endtask

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = SQRT_BIT_INIT;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] dist_sq(logic signed [31:0] v, logic signed [63:0] c);
        logic signed [63:0] d;
        d = 64'(v) - c;
        if (d < 0)
            d = -d;
        return d * d;
    endfunction

    // Take one accepted vertex; push a summary on the last mark.
    task automatic absorb_vertex(vertex_t v);
        logic signed [63:0] hx, hy, hz, cx, cy, cz;
        logic [63:0] far, d;
        summary_t s;
        far = 0;
        if (mesh_count < CAP)
        begin
            mesh_x[mesh_count] = v.x;
            mesh_y[mesh_count] = v.y;
            mesh_z[mesh_count] = v.z;
            mesh_count++;
            if (v.x < lo_x) lo_x = v.x;
            if (v.y < lo_y) lo_y = v.y;
            if (v.z < lo_z) lo_z = v.z;
            if (v.x > hi_x) hi_x = v.x;
            if (v.y > hi_y) hi_y = v.y;
            if (v.z > hi_z) hi_z = v.z;
        end
        else
            mesh_dropped = 1;
        if (!v.last)
            return;
        hx = (64'(hi_x) - 64'(lo_x)) >>> 1;
        hy = (64'(hi_y) - 64'(lo_y)) >>> 1;
        hz = (64'(hi_z) - 64'(lo_z)) >>> 1;
        cx = 64'(lo_x) + hx;
        cy = 64'(lo_y) + hy;
        cz = 64'(lo_z) + hz;
        for (int i = 0; i < mesh_count; i++)
        begin
            d = dist_sq(mesh_x[i], cx) + dist_sq(mesh_y[i], cy) + dist_sq(mesh_z[i], cz);
            if (d > far)
                far = d;
        end
        s.cx = cx[31:0]; s.cy = cy[31:0]; s.cz = cz[31:0];
        s.hx = hx[HALF_W-1:0]; s.hy = hy[HALF_W-1:0]; s.hz = hz[HALF_W-1:0];
        s.rad = RADIUS_W'(floor_sqrt(far));
        s.total = TOTAL_W'(mesh_count);
        s.ovf = mesh_dropped;
        summary_q.push_back(s);
        clear_mesh_state();
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // random coordinate: full range, small values or extremes
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3, 4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_vertex(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic last);
        vertex_t v;
        v.x = x; v.y = y; v.z = z; v.last = last;
        pending_q.push_back(v);
    endtask

    // Driver: bursts of requests with random gaps, changed on the falling edge.
    int burst_left = 0;
    int gap_left = 0;
    bit in_taken = 0;       // request accepted at the last rising edge
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !in_taken)
            ;   // request still waiting to be taken; hold it
        else
        begin
            if (start)
                void'(pending_q.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                pos_x   <= pending_q[0].x;
                pos_y   <= pending_q[0].y;
                pos_z   <= pending_q[0].z;
                is_last <= pending_q[0].last;
                start   <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predict on each accepted request, check each done strobe.
    always @(posedge clk)
    begin
        summary_t e;
        in_taken = rst_n && start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                vertex_t v;
                v.x = pos_x; v.y = pos_y; v.z = pos_z; v.last = is_last;
                absorb_vertex(v);
            end
            if (done)
            begin
                if (summary_q.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'd1, 64'd0);
                end
                else
                begin
                    e = summary_q.pop_front();
                    if (center_x !== e.cx) report_mismatch("center_x", center_x, e.cx);
                    if (center_y !== e.cy) report_mismatch("center_y", center_y, e.cy);
                    if (center_z !== e.cz) report_mismatch("center_z", center_z, e.cz);
                    if (half_x !== e.hx) report_mismatch("half_x", half_x, e.hx);
                    if (half_y !== e.hy) report_mismatch("half_y", half_y, e.hy);
                    if (half_z !== e.hz) report_mismatch("half_z", half_z, e.hz);
                    if (radius !== e.rad) report_mismatch("radius", radius, e.rad);
                    if (vertex_total !== e.total)
                        report_mismatch("vertex_total", vertex_total, e.total);
                    if (overflowed !== e.ovf) report_mismatch("overflowed", overflowed, e.ovf);
                end
            end
        end
    end

    initial
    begin
        int n;
        int left;
        rst_n = 1'b0;
        start = 1'b0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        is_last = 1'b0;
        clear_mesh_state();

        // directed: single vertex meshes, three of them at the extremes
        add_vertex(COORD_MAX, COORD_MIN, 0, 1);
        add_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1);
        add_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1);
        add_vertex(-1, 0, 1, 1);
        // widest span on every axis, odd span for the floor shift
        add_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 0);
        add_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1);
        add_vertex(-3, 0, 7, 0);
        add_vertex(0, 5, -2, 0);
        add_vertex(32'sh0001_0000, -32'sh0001_0000, 1, 1);
        // all-ones / alternating bit patterns
        add_vertex(32'sh5555_5555, 32'shAAAA_AAAA, -1, 0);
        add_vertex(32'shAAAA_AAAA, 32'sh5555_5555, 0, 1);

        // random meshes, mostly small
        left = 1940;
        while (left > 0)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
            if (n > left)
                n = left;
            for (int i = 0; i < n; i++)
                add_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
            left -= n;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && !start);
        wait (summary_q.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bbs_pkg.sv
rtl/bbs_ram.sv
rtl/bbs_ctrl.sv
rtl/bbs_dp.sv
rtl/mesh_bounding_box_and_sphere_unit.sv
sim/mesh_bounding_box_and_sphere_unit_tb.sv
